[hw/rtl/sqp_pkg.sv]
// Shared types and codes for the sorted priority rssi queue.
// Used by the cell, the cell row, the top level and the checker.
package sqp_pkg;

  typedef enum logic [1:0] {
    REQ_INSERT   = 2'd0,
    REQ_POP      = 2'd1,
    REQ_REINSERT = 2'd2,
    REQ_CLEAR    = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_DROPPED   = 3'd3,
    ST_POPPED    = 3'd4,
    ST_EMPTY     = 3'd5,
    ST_CLEARED   = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_POP    = 2'd2
  } cell_op_e;

  typedef struct packed {
    logic [15:0]        addr;
    logic signed [15:0] rssi;
    logic [3:0]         prio;
    logic [1:0]         retx;
    logic [15:0]        tag;
  } entry_t;

  typedef struct packed {
    cell_op_e op;
    logic     after_equal;  // place behind every entry of equal priority
  } cell_ctrl_t;

  localparam logic [3:0] PRIO_MAX_RESET = 4'd7;
  localparam int unsigned RETX_LIMIT_RAISE = 2;
  localparam int unsigned RETX_LIMIT_DROP  = 3;

endpackage

[hw/rtl/sqp_cell.sv]
// One slot of the sorted queue: holds an entry, compares it with the new one
// and shifts toward either neighbor. Depends on sqp_pkg.
module sqp_cell
  import sqp_pkg::*;
#(
  parameter int unsigned CNT_W = 5,
  parameter int unsigned IDX   = 0
) (
  input  logic             clk_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic [CNT_W-1:0] count_i,
  input  entry_t           new_i,
  input  entry_t           left_i,
  input  entry_t           right_i,
  input  logic             mark_i,
  output logic             mark_o,
  output logic             match_o,
  output entry_t           entry_o
);

  entry_t entry_q, entry_d;
  logic   valid, at_end, ahead;

  assign valid  = count_i > CNT_W'(IDX);
  assign at_end = count_i == CNT_W'(IDX);

  always_comb begin
    ahead = 1'b0;
    if (valid) begin
      if (entry_q.prio > new_i.prio) begin
        ahead = 1'b1;
      end else if (!ctrl_i.after_equal && entry_q.prio == new_i.prio &&
                   $signed(entry_q.rssi) <= $signed(new_i.rssi)) begin
        ahead = 1'b1;
      end
    end
  end

  // mark_i: the insertion point lies left of this cell
  assign mark_o  = mark_i | ahead | at_end;
  assign match_o = valid && (entry_q.addr == new_i.addr);

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        if (mark_i) begin
          entry_d = left_i;
        end else if (ahead || at_end) begin
          entry_d = new_i;
        end
      end
      CELL_POP: entry_d = right_i;
      default:  entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

[hw/rtl/sqp_chain.sv]
// Row of queue cells linked to their neighbors, head at index zero.
// Depends on sqp_pkg and sqp_cell.
module sqp_chain
  import sqp_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned CNT_W = 5
) (
  input  logic             clk_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic [CNT_W-1:0] count_i,
  input  entry_t           new_i,
  output logic             dup_o,
  output entry_t           head_o
);

  entry_t           entries [DEPTH];
  logic [DEPTH:0]   marks;
  logic [DEPTH-1:0] hits;

  assign marks[0] = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    entry_t left_e, right_e;
    if (g == 0) begin : g_first
      assign left_e = new_i;
    end else begin : g_mid
      assign left_e = entries[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_e = entries[g];
    end else begin : g_inner
      assign right_e = entries[g+1];
    end

    sqp_cell #(
      .CNT_W(CNT_W),
      .IDX  (g)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl_i),
      .count_i(count_i),
      .new_i  (new_i),
      .left_i (left_e),
      .right_i(right_e),
      .mark_i (marks[g]),
      .mark_o (marks[g+1]),
      .match_o(hits[g]),
      .entry_o(entries[g])
    );
  end

  assign dup_o  = |hits;
  assign head_o = entries[0];

endmodule

[hw/rtl/sorted_priority_rssi_queue.sv]
// Sorted priority rssi queue: a row of shift cells kept in service order.
// The result strobe comes in the cycle after an accepted start; one request
// per cycle, busy never rises, since every cell compares with the new entry
// and shifts in the same cycle. Reset (rst_ni low, async) empties the queue
// and sets priority_max to 7; cell contents are not cleared.
// Depends on sqp_pkg and sqp_chain.
module sorted_priority_rssi_queue
  import sqp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] node_address_i,
  input  logic signed [15:0] rssi_in_i,
  input  logic [3:0]  priority_in_i,
  input  logic [1:0]  retx_count_i,
  input  logic [15:0] ack_tag_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [15:0] out_address_o,
  output logic signed [15:0] out_rssi_o,
  output logic [3:0]  out_priority_o,
  output logic [1:0]  out_retx_count_o,
  output logic [15:0] out_ack_tag_o,
  output logic [4:0]  queue_count_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0] count_q, count_d;
  logic [3:0]       prio_max_q;
  logic             accept, dup, full;
  entry_t           new_e, head_e;
  cell_ctrl_t       ctrl;
  status_e          status;
  logic [2:0]       retx_next;
  logic [4:0]       prio_raised;

  logic        done_q;
  status_e     status_q;
  entry_t      out_q;
  logic [4:0]  qcount_q;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start & ~busy;
  assign full   = count_q >= CNT_W'(QUEUE_DEPTH);

  // Register file: priority_max is the only register, decoded from paddr[2] low (words 0 to 3)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prio_max_q <= PRIO_MAX_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      prio_max_q <= pwdata[3:0];
    end
  end

  assign prdata = paddr[2] ? 32'd0 : {28'd0, prio_max_q};

  assign retx_next   = {1'b0, retx_count_i} + 3'd1;
  assign prio_raised = {1'b0, priority_in_i} + 5'd1;

  always_comb begin
    new_e      = '0;
    new_e.addr = node_address_i;
    new_e.rssi = rssi_in_i;
    new_e.prio = priority_in_i;
    new_e.tag  = ack_tag_i;
    ctrl       = '{op: CELL_HOLD, after_equal: 1'b0};
    count_d    = count_q;
    status     = ST_INSERTED;
    unique case (req_e'(req_type_i))
      REQ_INSERT: begin
        if (dup) begin
          status = ST_DUPLICATE;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          ctrl.op = CELL_INSERT;
          count_d = count_q + CNT_W'(1);
        end
      end
      REQ_POP: begin
        if (count_q == '0) begin
          status = ST_EMPTY;
        end else begin
          status  = ST_POPPED;
          ctrl.op = CELL_POP;
          count_d = count_q - CNT_W'(1);
        end
      end
      REQ_REINSERT: begin
        new_e.retx       = retx_next[1:0];
        ctrl.after_equal = retx_next == 3'd1;
        if (retx_next == 3'(RETX_LIMIT_RAISE)) begin
          new_e.prio = prio_raised[3:0];
        end
        if (retx_next >= 3'(RETX_LIMIT_DROP) ||
            (retx_next == 3'(RETX_LIMIT_RAISE) && prio_raised > {1'b0, prio_max_q})) begin
          status = ST_DROPPED;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          ctrl.op = CELL_INSERT;
          count_d = count_q + CNT_W'(1);
        end
      end
      REQ_CLEAR: begin
        status  = ST_CLEARED;
        count_d = '0;
      end
      default: status = ST_INSERTED;
    endcase
    if (!accept) begin
      ctrl.op = CELL_HOLD;
      count_d = count_q;
    end
  end

  sqp_chain #(
    .DEPTH(QUEUE_DEPTH),
    .CNT_W(CNT_W)
  ) u_chain (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .count_i(count_q),
    .new_i  (new_e),
    .dup_o  (dup),
    .head_o (head_e)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  // Result payload: load on each transfer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status;
      out_q    <= (status == ST_POPPED) ? head_e : '0;
      qcount_q <= 5'(count_d);
    end
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign out_address_o    = out_q.addr;
  assign out_rssi_o       = out_q.rssi;
  assign out_priority_o   = out_q.prio;
  assign out_retx_count_o = out_q.retx;
  assign out_ack_tag_o    = out_q.tag;
  assign queue_count_o    = qcount_q;

endmodule

[hw/rtl/sqp_checker.sv]
// Port-level checks for the sorted priority rssi queue, bound to the top.
// Depends on sqp_pkg.
module sqp_checker
  import sqp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [2:0]  status_o,
  input logic [15:0] out_address_o,
  input logic [15:0] out_rssi_o,
  input logic [3:0]  out_priority_o,
  input logic [1:0]  out_retx_count_o,
  input logic [15:0] out_ack_tag_o,
  input logic [4:0]  queue_count_o
);

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("accepted request gave no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !done_o)
    else $error("result without a request");

  a_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_POPPED) |->
      (out_address_o == '0 && out_rssi_o == '0 && out_priority_o == '0 &&
       out_retx_count_o == '0 && out_ack_tag_o == '0))
    else $error("entry fields set on a non-pop result");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_CLEARED || status_o == ST_EMPTY)) |->
      queue_count_o == '0)
    else $error("count not zero after clear or empty pop");

endmodule

bind sorted_priority_rssi_queue sqp_checker u_sqp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .status_o        (status_o),
  .out_address_o   (out_address_o),
  .out_rssi_o      (out_rssi_o),
  .out_priority_o  (out_priority_o),
  .out_retx_count_o(out_retx_count_o),
  .out_ack_tag_o   (out_ack_tag_o),
  .queue_count_o   (queue_count_o)
);

[test/tb.sv]
// Testbench for sorted_priority_rssi_queue: directed and random requests checked
// against an in-bench model of the sorted queue and its priority_max register.
// Depends on sqp_pkg and the RTL of the queue.
`timescale 1ns / 100ps

module tb;
  import sqp_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam logic [2:0] PRIO_MAX_ADDR = 3'd0;  // register 0: priority_max
  localparam int unsigned MAX_PRINTED = 50;

  typedef struct {
    status_e     status;
    entry_t      ent;
    logic [4:0]  count;
  } reply_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [1:0]         req_type_i;
  logic [15:0]        node_address_i;
  logic signed [15:0] rssi_in_i;
  logic [3:0]         priority_in_i;
  logic [1:0]         retx_count_i;
  logic [15:0]        ack_tag_i;
  logic               done_o;
  logic [2:0]         status_o;
  logic [15:0]        out_address_o;
  logic signed [15:0] out_rssi_o;
  logic [3:0]         out_priority_o;
  logic [1:0]         out_retx_count_o;
  logic [15:0]        out_ack_tag_o;
  logic [4:0]         queue_count_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  // queue model state
  entry_t      held[DEPTH];
  int unsigned held_count;
  logic [3:0]  prio_limit;

  reply_t      pending_replies[$];
  reply_t      want;
  int unsigned error_count;
  int unsigned no_gap_left;

  sorted_priority_rssi_queue #(
    .QUEUE_DEPTH(DEPTH)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .req_type_i      (req_type_i),
    .node_address_i  (node_address_i),
    .rssi_in_i       (rssi_in_i),
    .priority_in_i   (priority_in_i),
    .retx_count_i    (retx_count_i),
    .ack_tag_i       (ack_tag_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .out_address_o   (out_address_o),
    .out_rssi_o      (out_rssi_o),
    .out_priority_o  (out_priority_o),
    .out_retx_count_o(out_retx_count_o),
    .out_ack_tag_o   (out_ack_tag_o),
    .queue_count_o   (queue_count_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint want_val,
                                 input longint got_val);
    error_count++;
    if (error_count <= MAX_PRINTED)
      $display("%0t ns: %s mismatch: expected %0d, got %0d", $time, what, want_val, got_val);
  endtask

  function automatic void place_entry(entry_t new_ent, bit after_equal);
    int unsigned pos;
    pos = held_count;
    for (int i = 0; i < held_count; i++) begin
      if (held[i].prio > new_ent.prio ||
          (!after_equal && held[i].prio == new_ent.prio &&
           $signed(held[i].rssi) <= $signed(new_ent.rssi))) begin
        pos = i;
        break;
      end
    end
    for (int i = held_count; i > pos; i--)
      held[i] = held[i-1];
    held[pos] = new_ent;
    held_count++;
  endfunction

  // Apply one request to the queue model and return the reply it should give.
  function automatic reply_t serve_request(req_e req, logic [15:0] addr,
                                           logic signed [15:0] rssi, logic [3:0] prio,
                                           logic [1:0] retx, logic [15:0] tag);
    reply_t r;
    entry_t new_ent;
    bit dup;
    bit drop;
    int unsigned tries;
    r.status = ST_INSERTED;
    r.ent = '0;
    new_ent.addr = addr;
    new_ent.rssi = rssi;
    new_ent.prio = prio;
    new_ent.retx = 2'd0;
    new_ent.tag = tag;
    dup = 1'b0;
    drop = 1'b0;
    tries = int'(retx) + 1;
    case (req)
      REQ_INSERT: begin
        for (int i = 0; i < held_count; i++)
          if (held[i].addr == addr) dup = 1'b1;
        if (dup) r.status = ST_DUPLICATE;
        else if (held_count >= DEPTH) r.status = ST_FULL;
        else place_entry(new_ent, 1'b0);
      end
      REQ_POP: begin
        if (held_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.ent = held[0];
          for (int i = 1; i < held_count; i++)
            held[i-1] = held[i];
          held_count--;
          r.status = ST_POPPED;
        end
      end
      REQ_REINSERT: begin
        if (tries == RETX_LIMIT_RAISE) begin
          if (int'(prio) + 1 > int'(prio_limit)) drop = 1'b1;
          else new_ent.prio = prio + 4'd1;
        end else if (tries >= RETX_LIMIT_DROP) begin
          drop = 1'b1;
        end
        if (drop) begin
          r.status = ST_DROPPED;
        end else if (held_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          new_ent.retx = tries[1:0];
          place_entry(new_ent, tries == 1);
        end
      end
      default: begin
        held_count = 0;
        r.status = ST_CLEARED;
      end
    endcase
    r.count = held_count[4:0];
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected result, status", -1, status_o);
      end else begin
        want = pending_replies.pop_front();
        if (status_o != want.status) report_mismatch("status", want.status, status_o);
        if (out_address_o != want.ent.addr)
          report_mismatch("out_address", want.ent.addr, out_address_o);
        if (out_rssi_o != want.ent.rssi)
          report_mismatch("out_rssi", $signed(want.ent.rssi), out_rssi_o);
        if (out_priority_o != want.ent.prio)
          report_mismatch("out_priority", want.ent.prio, out_priority_o);
        if (out_retx_count_o != want.ent.retx)
          report_mismatch("out_retx_count", want.ent.retx, out_retx_count_o);
        if (out_ack_tag_o != want.ent.tag)
          report_mismatch("out_ack_tag", want.ent.tag, out_ack_tag_o);
        if (queue_count_o != want.count)
          report_mismatch("queue_count", want.count, queue_count_o);
      end
    end
  end

  // Mostly short gaps, a few long ones, and now and then a stretch with none.
  task automatic insert_idle_gap();
    int unsigned roll;
    int unsigned gap;
    gap = 0;
    if (no_gap_left > 0) begin
      no_gap_left--;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 55) gap = 0;
      else if (roll < 85) gap = $urandom_range(1, 3);
      else if (roll < 93) gap = $urandom_range(4, 10);
      else if (roll < 96) gap = $urandom_range(20, 60);
      else no_gap_left = $urandom_range(20, 80);
    end
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_request(input req_e req, input logic [15:0] addr,
                              input logic signed [15:0] rssi, input logic [3:0] prio,
                              input logic [1:0] retx, input logic [15:0] tag);
    insert_idle_gap();
    req_type_i     = req;
    node_address_i = addr;
    rssi_in_i      = rssi;
    priority_in_i  = prio;
    retx_count_i   = retx;
    ack_tag_i      = tag;
    start          = 1'b1;
    do @(posedge clk_i); while (busy);
    pending_replies.push_back(serve_request(req, addr, rssi, prio, retx, tag));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    int unsigned waited;
    waited = 0;
    start = 1'b0;
    while (pending_replies.size() > 0 && waited < 1000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_priority_max(input logic [3:0] value);
    logic [31:0] readback;
    wait_drained();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = PRIO_MAX_ADDR;
    pwdata  = {28'd0, value};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    prio_limit = value;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    // read back
    psel = 1'b1;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    if (readback != {28'd0, value}) report_mismatch("priority_max readback", value, readback);
  endtask

  task automatic test_empty_and_extremes();
    send_request(REQ_POP, 16'h1234, 16'sh0001, 4'd3, 2'd1, 16'h5555);
    send_request(REQ_INSERT, 16'h0000, 16'sh8000, 4'd15, 2'd3, 16'h0000);
    send_request(REQ_INSERT, 16'hFFFF, 16'sh7FFF, 4'd0, 2'd0, 16'hFFFF);
    // same priority, rssi tie: goes ahead
    send_request(REQ_INSERT, 16'h0001, 16'sh7FFF, 4'd0, 2'd2, 16'hA5A5);
    send_request(REQ_INSERT, 16'hFFFF, 16'sh0000, 4'd5, 2'd0, 16'h1111);
    send_request(REQ_POP, 16'h0000, 16'sh0000, 4'd0, 2'd0, 16'h0000);
    send_request(REQ_POP, 16'hFFFF, 16'shFFFF, 4'd15, 2'd3, 16'hFFFF);
    send_request(REQ_POP, 16'h0000, 16'sh0000, 4'd0, 2'd0, 16'h0000);
    send_request(REQ_POP, 16'h0000, 16'sh0000, 4'd0, 2'd0, 16'h0000);
  endtask

  task automatic test_retransmit();
    send_request(REQ_INSERT, 16'd10, 16'sd5, 4'd3, 2'd0, 16'h0010);
    // count one lands behind equal priority even with higher rssi
    send_request(REQ_REINSERT, 16'd11, 16'sd100, 4'd3, 2'd0, 16'h0011);
    // held address does not block a reinsert; count two raises 2 to 3
    send_request(REQ_REINSERT, 16'd10, 16'sd50, 4'd2, 2'd1, 16'h0012);
    send_request(REQ_REINSERT, 16'd12, 16'sd1, 4'd7, 2'd1, 16'h0013);
    send_request(REQ_REINSERT, 16'd13, -16'sd1, 4'd6, 2'd1, 16'h0014);
    send_request(REQ_REINSERT, 16'd14, 16'sd0, 4'd15, 2'd1, 16'h0015);
    send_request(REQ_REINSERT, 16'd15, 16'sd0, 4'd0, 2'd2, 16'h0016);
    send_request(REQ_REINSERT, 16'd16, 16'sd0, 4'd0, 2'd3, 16'h0017);
    send_request(REQ_POP, 16'd0, 16'sd0, 4'd0, 2'd0, 16'd0);
    send_request(REQ_CLEAR, 16'd0, 16'sd0, 4'd0, 2'd0, 16'd0);
    send_request(REQ_POP, 16'd0, 16'sd0, 4'd0, 2'd0, 16'd0);
  endtask

  task automatic test_full_queue();
    for (int i = 0; i < DEPTH; i++)
      send_request(REQ_INSERT, 16'(100 + i), 16'(i * 3 - 20), 4'(i % 4), 2'd0, 16'(i));
    send_request(REQ_INSERT, 16'd200, 16'sd0, 4'd0, 2'd0, 16'd0);
    send_request(REQ_INSERT, 16'd105, 16'sd0, 4'd0, 2'd0, 16'd0);
    send_request(REQ_REINSERT, 16'd201, 16'sd0, 4'd1, 2'd0, 16'd0);
    send_request(REQ_REINSERT, 16'd202, 16'sd0, 4'd1, 2'd2, 16'd0);
    send_request(REQ_POP, 16'd0, 16'sd0, 4'd0, 2'd0, 16'd0);
    send_request(REQ_CLEAR, 16'd0, 16'sd0, 4'd0, 2'd0, 16'd0);
  endtask

  task automatic test_priority_max();
    logic [3:0] limits[3];
    logic [3:0] lim;
    limits = '{4'd0, 4'd14, 4'd1};
    foreach (limits[k]) begin
      lim = limits[k];
      write_priority_max(lim);
      send_request(REQ_REINSERT, 16'd300, 16'sd7, lim, 2'd1, 16'hBEEF);
      send_request(REQ_REINSERT, 16'd301, -16'sd7, (lim == 0) ? 4'd0 : lim - 4'd1, 2'd1,
                   16'hCAFE);
      send_request(REQ_POP, 16'd0, 16'sd0, 4'd0, 2'd0, 16'd0);
      send_request(REQ_CLEAR, 16'd0, 16'sd0, 4'd0, 2'd0, 16'd0);
    end
  endtask

  task automatic test_random_traffic();
    int unsigned roll;
    logic [3:0] lim;
    req_e req;
    logic [15:0] addr;
    logic signed [15:0] rssi;
    logic [3:0] prio;
    for (int phase = 0; phase < 9; phase++) begin
      if (phase == 0) lim = 4'd14;
      else if (phase == 1) lim = 4'd0;
      else if (phase == 2) lim = PRIO_MAX_RESET;
      else lim = 4'($urandom_range(0, 14));
      write_priority_max(lim);
      repeat (200) begin
        roll = $urandom_range(0, 99);
        // even phases grow the queue toward full, odd phases drain it
        if (phase % 2 == 0)
          req = (roll < 50) ? REQ_INSERT : (roll < 75) ? REQ_REINSERT :
                (roll < 98) ? REQ_POP : REQ_CLEAR;
        else
          req = (roll < 25) ? REQ_INSERT : (roll < 43) ? REQ_REINSERT :
                (roll < 98) ? REQ_POP : REQ_CLEAR;
        roll = $urandom_range(0, 9);
        if (roll < 5) addr = 16'($urandom_range(0, 15));
        else if (roll < 7 && held_count > 0) addr = held[$urandom_range(0, held_count - 1)].addr;
        else addr = 16'($urandom);
        case ($urandom_range(0, 5))
          0: rssi = 16'sh8000;
          1: rssi = 16'sh7FFF;
          2: rssi = 16'($urandom_range(0, 6)) - 16'sd3;
          default: rssi = 16'($urandom);
        endcase
        prio = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3)) : 4'($urandom);
        send_request(req, addr, rssi, prio, 2'($urandom), 16'($urandom));
        if ($urandom_range(0, 149) == 0) wait_drained();
      end
    end
  endtask

  initial begin
    int unsigned waited;
    error_count    = 0;
    no_gap_left    = 0;
    held_count     = 0;
    prio_limit     = PRIO_MAX_RESET;
    rst_ni         = 1'b0;
    start          = 1'b0;
    req_type_i     = REQ_INSERT;
    node_address_i = '0;
    rssi_in_i      = '0;
    priority_in_i  = '0;
    retx_count_i   = '0;
    ack_tag_i      = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_and_extremes();
    test_retransmit();
    test_full_queue();
    test_priority_max();
    test_random_traffic();

    start = 1'b0;
    waited = 0;
    while (pending_replies.size() > 0 && waited < 1000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (5) @(negedge clk_i);
    if (pending_replies.size() != 0)
      report_mismatch("results still outstanding", 0, pending_replies.size());

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
